// ----- rtl/core/ffba_pkg.sv -----
// Shared types, codes and the control store for the first-fit block allocator.
// No dependencies; imported by ffba_seq, ffba_dp and first_fit_block_allocator.
package ffba_pkg;

  // Microprogram step addresses.
  typedef logic [4:0] step_t;
  localparam step_t U_CLR   = 5'd1;
  localparam step_t U_CHK   = 5'd2;
  localparam step_t U_IDLE  = 5'd3;
  localparam step_t U_KIND  = 5'd4;
  localparam step_t U_A0    = 5'd5;
  localparam step_t U_WALK  = 5'd6;
  localparam step_t U_W2    = 5'd7;
  localparam step_t U_SCAN  = 5'd8;
  localparam step_t U_S1    = 5'd9;
  localparam step_t U_S2    = 5'd10;
  localparam step_t U_HIT   = 5'd11;
  localparam step_t U_JMP   = 5'd12;
  localparam step_t U_PLACE = 5'd13;
  localparam step_t U_FAIL  = 5'd14;
  localparam step_t U_F0    = 5'd15;
  localparam step_t U_F1    = 5'd16;
  localparam step_t U_F2    = 5'd17;
  localparam step_t U_DONE  = 5'd18;
  localparam step_t U_RET   = 5'd19;

  // Request kind and register index codes.
  localparam logic KIND_FREE  = 1'b1;
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_WORDS  = 1'b1;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_CLR_PEND,
    C_CLR_MORE,
    C_NO_TAKE,
    C_KIND_FREE,
    C_ALLOC_BAD,
    C_FREE_BAD,
    C_POS_END,
    C_MARK,
    C_NOMARK,
    C_FIT,
    C_Q_END,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {P_HOLD, P_ZERO, P_SKIP, P_FROM_Q} pos_op_t;
  typedef enum logic [1:0] {Q_HOLD, Q_POS, Q_INC_CLEAR} q_op_t;
  typedef enum logic [1:0] {R_NONE, R_POS, R_Q, R_H} rd_op_t;
  typedef enum logic [1:0] {W_NONE, W_PLACE, W_FREE, W_CLR} wr_op_t;
  typedef enum logic [1:0] {RS_HOLD, RS_ALLOC, RS_FREE, RS_FAIL} res_op_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    pos_op_t pos_op;
    q_op_t   q_op;
    rd_op_t  rd_op;
    wr_op_t  wr_op;
    res_op_t res_op;
    logic    take;
    logic    out_load;
  } ucode_t;

  typedef struct packed {
    logic clr_pend;
    logic clr_more;
    logic no_take;
    logic kind_free;
    logic alloc_bad;
    logic free_bad;
    logic pos_end;
    logic mark;
    logic fit;
    logic q_end;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic        heap_enabled;
    logic [10:0] heap_words;
  } cfg_t;

  function automatic ucode_t uw(input cond_t c, input step_t t, input pos_op_t p,
                                input q_op_t q, input rd_op_t r, input wr_op_t w,
                                input res_op_t s, input logic tk, input logic ld);
    ucode_t u;
    u.cond     = c;
    u.target   = t;
    u.pos_op   = p;
    u.q_op     = q;
    u.rd_op    = r;
    u.wr_op    = w;
    u.res_op   = s;
    u.take     = tk;
    u.out_load = ld;
    return u;
  endfunction

  // Control store. A step jumps to target when its condition holds, else falls through.
  function automatic ucode_t ucode_rom(input step_t a);
    ucode_t u;
    unique case (a)
      U_CLR:   u = uw(C_CLR_MORE,  U_CLR,   P_HOLD,   Q_HOLD,      R_NONE, W_CLR,
                      RS_HOLD,  1'b0, 1'b0);
      U_CHK:   u = uw(C_CLR_PEND,  U_CLR,   P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_IDLE:  u = uw(C_NO_TAKE,   U_CHK,   P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b1, 1'b0);
      U_KIND:  u = uw(C_KIND_FREE, U_F0,    P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_A0:    u = uw(C_ALLOC_BAD, U_FAIL,  P_ZERO,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_WALK:  u = uw(C_POS_END,   U_FAIL,  P_HOLD,   Q_HOLD,      R_POS,  W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_W2:    u = uw(C_MARK,      U_JMP,   P_HOLD,   Q_POS,       R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_SCAN:  u = uw(C_FIT,       U_PLACE, P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_S1:    u = uw(C_Q_END,     U_FAIL,  P_HOLD,   Q_HOLD,      R_Q,    W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_S2:    u = uw(C_NOMARK,    U_SCAN,  P_HOLD,   Q_INC_CLEAR, R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_HIT:   u = uw(C_ALWAYS,    U_WALK,  P_FROM_Q, Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_JMP:   u = uw(C_ALWAYS,    U_WALK,  P_SKIP,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_PLACE: u = uw(C_ALWAYS,    U_DONE,  P_HOLD,   Q_HOLD,      R_NONE, W_PLACE,
                      RS_ALLOC, 1'b0, 1'b0);
      U_FAIL:  u = uw(C_ALWAYS,    U_DONE,  P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_FAIL,  1'b0, 1'b0);
      U_F0:    u = uw(C_FREE_BAD,  U_FAIL,  P_HOLD,   Q_HOLD,      R_H,    W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_F1:    u = uw(C_NOMARK,    U_FAIL,  P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      U_F2:    u = uw(C_ALWAYS,    U_DONE,  P_HOLD,   Q_HOLD,      R_NONE, W_FREE,
                      RS_FREE,  1'b0, 1'b0);
      // wait here until the output register is free, then back to idle
      U_DONE:  u = uw(C_OUT_BUSY,  U_DONE,  P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b1);
      U_RET:   u = uw(C_ALWAYS,    U_CHK,   P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
      default: u = uw(C_ALWAYS,    U_CHK,   P_HOLD,   Q_HOLD,      R_NONE, W_NONE,
                      RS_HOLD,  1'b0, 1'b0);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/first_fit_block_allocator.sv -----
// First-fit block allocator: config registers, sequencer and datapath.
// An allocate walks the store from offset 0, skipping each marked block and scanning
// free words until a gap fits the request plus its header, failing at the region end;
// each walk step waits on one read of the mark/length store.
// One request at a time; the next beat is taken after a result is loaded for output.
// Reset (synchronous) and each enabling write start a clearing pass over all
// MEM_WORDS store words, during which input beats are stalled.
module first_fit_block_allocator #(
  parameter int MEM_WORDS = 1024,
  parameter int HDR_WORDS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [9:0]  req_size,
  input  logic [9:0]  free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        granted,
  output logic [9:0]  block_offset
);
  import ffba_pkg::*;

  logic        heap_enabled;
  logic [10:0] heap_words;
  logic        wr_en, enable_rise;
  cfg_t        cfg;
  ucode_t      uc;
  status_t     st;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite && pready;
  assign enable_rise = wr_en && paddr[2] == REG_ENABLE && pwdata[0] && !heap_enabled;
  assign prdata      = (paddr[2] == REG_WORDS) ? {21'b0, heap_words}
                                               : {31'b0, heap_enabled};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_enabled <= 1'b0;
      heap_words   <= '0;
    end else if (wr_en) begin
      if (paddr[2] == REG_WORDS) begin
        heap_words <= pwdata[10:0];
      end else begin
        heap_enabled <= pwdata[0];
      end
    end
  end

  always_comb begin
    cfg.heap_enabled = heap_enabled;
    cfg.heap_words   = heap_words;
  end

  ffba_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .uc  (uc)
  );

  ffba_dp #(
    .MEM_WORDS (MEM_WORDS),
    .HDR_WORDS (HDR_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .enable_rise  (enable_rise),
    .uc           (uc),
    .st           (st),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .req_size     (req_size),
    .free_offset  (free_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted      (granted),
    .block_offset (block_offset)
  );

endmodule

// ----- rtl/core/ffba_seq.sv -----
// Microcode sequencer: step counter, control store lookup and branch select.
// Depends on ffba_pkg.
module ffba_seq (
  input  logic              clk,
  input  logic              rst,
  input  ffba_pkg::status_t st,
  output ffba_pkg::ucode_t  uc
);
  import ffba_pkg::*;

  step_t upc, upc_next;
  logic  taken;

  always_comb uc = ucode_rom(upc);

  always_comb begin
    case (uc.cond)
      C_ALWAYS:    taken = 1'b1;
      C_CLR_PEND:  taken = st.clr_pend;
      C_CLR_MORE:  taken = st.clr_more;
      C_NO_TAKE:   taken = st.no_take;
      C_KIND_FREE: taken = st.kind_free;
      C_ALLOC_BAD: taken = st.alloc_bad;
      C_FREE_BAD:  taken = st.free_bad;
      C_POS_END:   taken = st.pos_end;
      C_MARK:      taken = st.mark;
      C_NOMARK:    taken = !st.mark;
      C_FIT:       taken = st.fit;
      C_Q_END:     taken = st.q_end;
      C_OUT_BUSY:  taken = st.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  always_comb upc_next = taken ? uc.target : upc + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_CHK;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ----- rtl/core/ffba_dp.sv -----
// Allocator datapath: request latches, walk/scan pointers, mark/length store,
// clearing pass and the output register. Depends on ffba_pkg.
module ffba_dp #(
  parameter int MEM_WORDS = 1024,
  parameter int HDR_WORDS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  ffba_pkg::cfg_t    cfg,
  input  logic              enable_rise,
  input  ffba_pkg::ucode_t  uc,
  output ffba_pkg::status_t st,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [9:0]        req_size,
  input  logic [9:0]        free_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              granted,
  output logic [9:0]        block_offset
);
  import ffba_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  // holds pos + header + largest length
  localparam int PW = $clog2(MEM_WORDS + 1032);

  logic [PW-1:0] pos, q, end_r, end_now, need, h, skip, pay_off, rd_addr, wr_addr;
  logic          kind_r;
  logic [9:0]    size_r, off_r;
  logic [10:0]   mem [MEM_WORDS];
  logic [10:0]   rd_q, wr_data;
  logic          rd_mark;
  logic [9:0]    rd_len;
  logic [AW-1:0] cnt;
  logic          clr_pend, clr_more, accept;
  logic          res_granted;
  logic [9:0]    res_off;

  assign in_stall = !(uc.take && !clr_pend);
  assign accept   = in_valid && !in_stall;

  assign end_now = (PW'(cfg.heap_words) > PW'(MEM_WORDS)) ? PW'(MEM_WORDS)
                                                          : PW'(cfg.heap_words);
  assign need    = PW'(size_r) + PW'(HDR_WORDS);
  assign h       = PW'(off_r) - PW'(HDR_WORDS);
  assign rd_mark = rd_q[10];
  assign rd_len  = rd_q[9:0];
  assign skip    = pos + PW'(HDR_WORDS) + PW'(rd_len);
  assign pay_off = pos + PW'(HDR_WORDS);
  assign clr_more = cnt != AW'(MEM_WORDS - 1);

  always_comb begin
    st.clr_pend  = clr_pend;
    st.clr_more  = clr_more;
    st.no_take   = !accept;
    st.kind_free = kind_r == KIND_FREE;
    st.alloc_bad = !cfg.heap_enabled || size_r == 10'd0 || PW'(size_r) > end_r;
    st.free_bad  = !cfg.heap_enabled || PW'(off_r) < PW'(HDR_WORDS) || h >= end_r;
    st.pos_end   = pos >= end_r;
    st.mark      = rd_mark;
    st.fit       = (q - pos) >= need;
    st.q_end     = q >= end_r;
    st.out_busy  = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      size_r <= req_size;
      off_r  <= free_offset;
      end_r  <= end_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      q   <= '0;
    end else begin
      case (uc.pos_op)
        P_ZERO:   pos <= '0;
        P_SKIP:   pos <= skip;
        P_FROM_Q: pos <= q;
        default:  pos <= pos;
      endcase
      case (uc.q_op)
        Q_POS:       q <= pos;
        Q_INC_CLEAR: if (!rd_mark) q <= q + PW'(1);
        default:     q <= q;
      endcase
    end
  end

  // mark/length store
  always_comb begin
    case (uc.rd_op)
      R_Q:     rd_addr = q;
      R_H:     rd_addr = h;
      default: rd_addr = pos;
    endcase
    case (uc.wr_op)
      W_PLACE: begin
        wr_addr = pos;
        wr_data = {1'b1, size_r};
      end
      W_FREE: begin
        wr_addr = h;
        wr_data = {1'b0, rd_len};
      end
      default: begin
        wr_addr = PW'(cnt);
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.wr_op != W_NONE) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (uc.rd_op != R_NONE) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // clearing pass after reset and when the heap is enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_pend <= 1'b1;
      cnt      <= '0;
    end else begin
      if (enable_rise) clr_pend <= 1'b1;
      if (uc.wr_op == W_CLR) begin
        if (clr_more) begin
          cnt <= cnt + AW'(1);
        end else begin
          cnt      <= '0;
          clr_pend <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uc.res_op)
      RS_ALLOC: begin
        res_granted <= 1'b1;
        res_off     <= pay_off[9:0];
      end
      RS_FREE: begin
        res_granted <= 1'b1;
        res_off     <= '0;
      end
      RS_FAIL: begin
        res_granted <= 1'b0;
        res_off     <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uc.out_load && !st.out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.out_load && !st.out_busy) begin
      granted      <= res_granted;
      block_offset <= res_off;
    end
  end

  // reads whose data the walk or a free goes on to use stay inside the store
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    (uc.rd_op == R_POS && !st.pos_end) || (uc.rd_op == R_Q && !st.q_end) ||
    (uc.rd_op == R_H && !st.free_bad) |-> rd_addr < PW'(MEM_WORDS))
    else $error("store read beyond its depth");

  a_place_fits: assert property (@(posedge clk) disable iff (rst)
    uc.wr_op == W_PLACE |-> (pos + need) <= end_r)
    else $error("block placed past region end");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> block_offset == '0)
    else $error("failed result carries an offset");

  a_clr_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_pend) |-> cnt == '0)
    else $error("clearing pass ended early");

endmodule
